[rtl/core/ole_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared constants, command codes and the controller/datapath status type.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Field widths of the request and result transactions.
    localparam int OP_W    = 4;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_ADDHEAD   = 4'd0;
    localparam logic [OP_W-1:0] OP_ADDTAIL   = 4'd1;
    localparam logic [OP_W-1:0] OP_RMHEAD    = 4'd2;
    localparam logic [OP_W-1:0] OP_RMTAIL    = 4'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd4;
    localparam logic [OP_W-1:0] OP_RMBEFORE  = 4'd5;
    localparam logic [OP_W-1:0] OP_RMAFTER   = 4'd6;
    localparam logic [OP_W-1:0] OP_ADDPOS    = 4'd7;
    localparam logic [OP_W-1:0] OP_ADDBEFORE = 4'd8;
    localparam logic [OP_W-1:0] OP_ADDAFTER  = 4'd9;
    localparam logic [OP_W-1:0] OP_COUNT     = 4'd10;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // List edit chosen for a request.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_INS   = 2'd1;
    localparam logic [1:0] ACT_DEL   = 2'd2;
    localparam logic [1:0] ACT_TRUNC = 2'd3;

    // Datapath commands issued by the controller.
    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NONE     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN_RD  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN_CMP = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DECIDE   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SHIFT_RD = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SHIFT_WR = 4'd6;
    localparam logic [CMD_W-1:0] CMD_COMMIT   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_OUT      = 4'd8;

    typedef struct packed {
        logic       scan_end;   // scan index has reached the list length
        logic       shift_end;  // no more entries to move
        logic [1:0] act;        // edit that the current request calls for
    } ole_stat_t;

endpackage

[rtl/core/ordered_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of up to DEPTH signed keys with head, tail and match-relative
// insert and remove, positional insert, clear and match count.
//
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid/in_ready    opcode, data_key, match_value,
//                                             position
//   result    out        out_valid/out_ready  status, length, match_count
//
// After acceptance the list is scanned for matches; then any edit moves
// entries, writes the key or cuts the length, and the edited list is scanned
// again to count matches before the result is loaded. A tail removal or clear
// moves no entries, and a request with no edit skips the edit and the rescan.
// in_ready is high only while idle, at the earliest the cycle after the result is loaded.
// Reset empties the list at once; the key memory is not cleared. A held
// result does not block the next request, whose result then waits.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ole_pkg::OP_W-1:0]          opcode,
    input  logic signed [ole_pkg::KEY_W-1:0]  data_key,
    input  logic signed [ole_pkg::KEY_W-1:0]  match_value,
    input  logic signed [ole_pkg::POS_W-1:0]  position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ole_pkg::STAT_W-1:0]        status,
    output logic [ole_pkg::LEN_W-1:0]         length,
    output logic [ole_pkg::LEN_W-1:0]         match_count
);

    ole_pkg::ole_stat_t        stat;
    logic [ole_pkg::CMD_W-1:0] cmd;

    ole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ole_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .data_key    (data_key),
        .match_value (match_value),
        .position    (position),
        .status      (status),
        .length      (length),
        .match_count (match_count)
    );

`ifndef SYNTH
    // One request at a time: acceptance closes the input until the work ends.
    a_single_request : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in progress");

    // A full refusal is only reported for a full list.
    a_full_length : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ole_pkg::ST_FULL) |-> (length == ole_pkg::LEN_W'(DEPTH)))
        else $error("full status with list not full");

    // Matches are counted among stored keys only.
    a_match_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && DEPTH < 32) |-> (match_count <= length))
        else $error("match count exceeds list length");

    // A new result is only loaded once the previous one has been taken.
    a_result_order : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");
`endif

endmodule

[rtl/core/ole_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine datapath
// Key memory, request registers, scan counters, edit decision and result.
// ----------------------------------------------------------------------------
module ole_datapath #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ole_pkg::CMD_W-1:0]         cmd,
    output ole_pkg::ole_stat_t                stat,
    input  logic [ole_pkg::OP_W-1:0]          opcode,
    input  logic signed [ole_pkg::KEY_W-1:0]  data_key,
    input  logic signed [ole_pkg::KEY_W-1:0]  match_value,
    input  logic signed [ole_pkg::POS_W-1:0]  position,
    output logic [ole_pkg::STAT_W-1:0]        status,
    output logic [ole_pkg::LEN_W-1:0]         length,
    output logic [ole_pkg::LEN_W-1:0]         match_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [ole_pkg::KEY_W-1:0] mem [DEPTH];
    logic [ole_pkg::KEY_W-1:0] rd_data_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] first_reg, first_next;
    logic [CW-1:0] mcnt_reg, mcnt_next;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic          found_reg, found_next;
    logic [1:0]    act_reg, act_next;
    logic [ole_pkg::STAT_W-1:0] st_reg, st_next;

    logic [ole_pkg::OP_W-1:0]          op_reg, op_next;
    logic [ole_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [ole_pkg::KEY_W-1:0]         mv_reg, mv_next;
    logic signed [ole_pkg::POS_W-1:0]  pos_reg, pos_next;

    logic [ole_pkg::STAT_W-1:0] status_reg, status_next;
    logic [ole_pkg::LEN_W-1:0]  length_reg, length_next;
    logic [ole_pkg::LEN_W-1:0]  mcount_reg, mcount_next;

    logic                      rd_en, wr_en;
    logic [IW-1:0]             rd_addr, wr_addr;
    logic [ole_pkg::KEY_W-1:0] wr_data;
    logic [CW-1:0]             rd_pos;

    logic          full, pos_fit, hit;
    logic [1:0]    dec_act;
    logic [CW-1:0] dec_tgt;
    logic [ole_pkg::STAT_W-1:0] dec_st;

    assign full    = (count_reg == CW'(DEPTH));
    assign pos_fit = (32'(pos_reg[4:0]) <= 32'(count_reg));
    assign hit     = (rd_data_reg == mv_reg);

    // Pick the edit for the request from the first scan's results.
    always_comb
    begin
        dec_act = ole_pkg::ACT_NONE;
        dec_tgt = '0;
        dec_st  = ole_pkg::ST_NONE;
        case (op_reg)
            ole_pkg::OP_ADDHEAD:
            begin
                if (full) dec_st = ole_pkg::ST_FULL;
                else
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_ADDTAIL:
            begin
                if (full) dec_st = ole_pkg::ST_FULL;
                else
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_tgt = count_reg;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_RMHEAD:
            begin
                if (count_reg != '0)
                begin
                    dec_act = ole_pkg::ACT_DEL;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_RMTAIL:
            begin
                if (count_reg != '0)
                begin
                    dec_act = ole_pkg::ACT_TRUNC;
                    dec_tgt = count_reg - 1'b1;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_CLEAR:
            begin
                if (count_reg != '0)
                begin
                    dec_act = ole_pkg::ACT_TRUNC;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_RMBEFORE:
            begin
                if (found_reg && first_reg != '0)
                begin
                    dec_act = ole_pkg::ACT_DEL;
                    dec_tgt = first_reg - 1'b1;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_RMAFTER:
            begin
                if (found_reg && (first_reg + 1'b1) < count_reg)
                begin
                    dec_act = ole_pkg::ACT_DEL;
                    dec_tgt = first_reg + 1'b1;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_ADDPOS:
            begin
                if (full) dec_st = ole_pkg::ST_FULL;
                else if (pos_reg[ole_pkg::POS_W-1] || pos_reg == '0)
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_st  = ole_pkg::ST_DONE;
                end
                else if (pos_fit)
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_tgt = CW'(pos_reg[4:0]);
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_ADDBEFORE:
            begin
                if (full) dec_st = ole_pkg::ST_FULL;
                else if (found_reg)
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_tgt = first_reg;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_ADDAFTER:
            begin
                if (full) dec_st = ole_pkg::ST_FULL;
                else if (found_reg)
                begin
                    dec_act = ole_pkg::ACT_INS;
                    dec_tgt = first_reg + 1'b1;
                    dec_st  = ole_pkg::ST_DONE;
                end
            end
            ole_pkg::OP_COUNT:
            begin
                dec_st = ole_pkg::ST_DONE;
            end
            default:
            begin
                dec_st = ole_pkg::ST_NONE;
            end
        endcase
    end

    assign stat.act      = dec_act;
    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.shift_end = (act_reg == ole_pkg::ACT_INS) ? (idx_reg == tgt_reg)
                          : (({1'b0, idx_reg} + 1'b1) >= {1'b0, count_reg});

    // Inserts move entries up from the tail; removals pull them down.
    assign rd_pos  = (cmd == ole_pkg::CMD_SCAN_RD) ? idx_reg
                   : (act_reg == ole_pkg::ACT_INS) ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
    assign rd_addr = rd_pos[IW-1:0];

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        mcnt_next   = mcnt_reg;
        tgt_next    = tgt_reg;
        found_next  = found_reg;
        act_next    = act_reg;
        st_next     = st_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        mv_next     = mv_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        length_next = length_reg;
        mcount_next = mcount_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[IW-1:0];
        wr_data     = rd_data_reg;
        case (cmd)
            ole_pkg::CMD_LOAD:
            begin
                op_next    = opcode;
                key_next   = data_key;
                mv_next    = match_value;
                pos_next   = position;
                idx_next   = '0;
                first_next = '0;
                mcnt_next  = '0;
                found_next = 1'b0;
            end
            ole_pkg::CMD_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            ole_pkg::CMD_SCAN_CMP:
            begin
                if (hit)
                begin
                    mcnt_next = mcnt_reg + 1'b1;
                    if (!found_reg)
                    begin
                        first_next = idx_reg;
                        found_next = 1'b1;
                    end
                end
                idx_next = idx_reg + 1'b1;
            end
            ole_pkg::CMD_DECIDE:
            begin
                act_next = dec_act;
                tgt_next = dec_tgt;
                st_next  = dec_st;
                idx_next = (dec_act == ole_pkg::ACT_INS) ? count_reg : dec_tgt;
            end
            ole_pkg::CMD_SHIFT_RD:
            begin
                rd_en = 1'b1;
            end
            ole_pkg::CMD_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                idx_next = (act_reg == ole_pkg::ACT_INS) ? (idx_reg - 1'b1)
                                                         : (idx_reg + 1'b1);
            end
            ole_pkg::CMD_COMMIT:
            begin
                case (act_reg)
                    ole_pkg::ACT_INS:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tgt_reg[IW-1:0];
                        wr_data    = key_reg;
                        count_next = count_reg + 1'b1;
                    end
                    ole_pkg::ACT_DEL:   count_next = count_reg - 1'b1;
                    ole_pkg::ACT_TRUNC: count_next = tgt_reg;
                    default:            count_next = count_reg;
                endcase
                // Restart the scan to count matches in the edited list.
                idx_next   = '0;
                mcnt_next  = '0;
                found_next = 1'b0;
            end
            ole_pkg::CMD_OUT:
            begin
                status_next = st_reg;
                length_next = ole_pkg::LEN_W'(count_reg);
                mcount_next = ole_pkg::LEN_W'(mcnt_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        first_reg  <= first_next;
        mcnt_reg   <= mcnt_next;
        tgt_reg    <= tgt_next;
        found_reg  <= found_next;
        act_reg    <= act_next;
        st_reg     <= st_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        mv_reg     <= mv_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        length_reg <= length_next;
        mcount_reg <= mcount_next;
    end

    assign status      = status_reg;
    assign length      = length_reg;
    assign match_count = mcount_reg;

endmodule

[rtl/core/ole_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine controller
// Sequences scan, edit, rescan and result hand-off for each request.
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  ole_pkg::ole_stat_t        stat,
    output logic [ole_pkg::CMD_W-1:0] cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_COMMIT   = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        cmd            = ole_pkg::CMD_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = ole_pkg::CMD_LOAD;
                    pass_next  = 1'b0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    state_next = pass_reg ? S_FINISH : S_DECIDE;
                end
                else
                begin
                    cmd        = ole_pkg::CMD_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                cmd        = ole_pkg::CMD_SCAN_CMP;
                state_next = S_SCAN_RD;
            end
            S_DECIDE:
            begin
                cmd = ole_pkg::CMD_DECIDE;
                case (stat.act)
                    ole_pkg::ACT_NONE:  state_next = S_FINISH;
                    ole_pkg::ACT_TRUNC: state_next = S_COMMIT;
                    default:            state_next = S_SHIFT_RD;
                endcase
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_end)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd        = ole_pkg::CMD_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd        = ole_pkg::CMD_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_COMMIT:
            begin
                cmd        = ole_pkg::CMD_COMMIT;
                pass_next  = 1'b1;
                state_next = S_SCAN_RD;
            end
            S_FINISH:
            begin
                // The result register must be empty or emptying this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = ole_pkg::CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
